// File: rtl/kvt_pkg.sv
`default_nettype none
package kvt_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DELETED  = 3'd2;
    localparam logic [2:0] ST_FOUND    = 3'd3;
    localparam logic [2:0] ST_MISSING  = 3'd4;

    localparam int KEY_W = 64;
    localparam int VAL_W = 64;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } t_ctl;

endpackage
`default_nettype wire

// File: rtl/kvt_cell.sv
`default_nettype none
module kvt_cell #(
    parameter int IDX = 0,
    parameter int CW  = 8
) (
    input  wire logic                     i_clk,
    input  wire kvt_pkg::t_ctl            i_ctl,
    input  wire kvt_pkg::t_cmd            i_cmd,
    input  wire logic [CW-1:0]            i_count,
    input  wire logic                     i_shift,
    input  wire logic [kvt_pkg::KEY_W-1:0] i_next_key,
    input  wire logic [kvt_pkg::VAL_W-1:0] i_next_value,
    output logic [kvt_pkg::KEY_W-1:0]     o_key,
    output logic [kvt_pkg::VAL_W-1:0]     o_value,
    output logic                          o_hit
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [kvt_pkg::KEY_W-1:0] r_key;
    logic [kvt_pkg::VAL_W-1:0] r_value;
    logic                      r_hit;
    logic                      w_used;

    assign w_used = MY_IDX < i_count;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_hit <= w_used && (r_key == i_cmd.key);
        end
        if (i_ctl.ins && (MY_IDX == i_count)) begin
            r_key   <= i_cmd.key;
            r_value <= i_cmd.value;
        end else if (i_ctl.del && i_shift) begin
            r_key   <= i_next_key;
            r_value <= i_next_value;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_hit   = r_hit;

endmodule
`default_nettype wire

// File: rtl/kvt_scan.sv
`default_nettype none
module kvt_scan #(
    parameter int ENTRIES = 128
) (
    input  wire logic [ENTRIES-1:0]        i_hit,
    input  wire logic [kvt_pkg::VAL_W-1:0] i_values [ENTRIES],
    output logic [ENTRIES-1:0]             o_at_or_after,
    output logic                           o_any,
    output logic [kvt_pkg::VAL_W-1:0]      o_found_value
);

    localparam int LV = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [ENTRIES-1:0] w_lvl [LV+1];
    logic [ENTRIES-1:0] w_first;

    // Parallel prefix OR: bit i is set at or after the lowest hit.
    always_comb begin
        w_lvl[0] = i_hit;
        for (int l = 0; l < LV; l++) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (i >= (1 << l)) begin
                    w_lvl[l+1][i] = w_lvl[l][i] | w_lvl[l][i - (1 << l)];
                end else begin
                    w_lvl[l+1][i] = w_lvl[l][i];
                end
            end
        end
    end

    assign o_at_or_after = w_lvl[LV];
    assign o_any         = w_lvl[LV][ENTRIES-1];

    always_comb begin
        w_first[0] = i_hit[0];
        for (int i = 1; i < ENTRIES; i++) begin
            w_first[i] = i_hit[i] & ~w_lvl[LV][i-1];
        end
    end

    always_comb begin
        o_found_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            o_found_value = o_found_value | (i_values[i] & {kvt_pkg::VAL_W{w_first[i]}});
        end
    end

endmodule
`default_nettype wire

// File: rtl/compacting_key_value_table.sv
// After its transfer, each request passes through S_CMP, which compares the key in every
// cell, and S_ACT, which resolves the first match, updates the cells and loads the result
// register; S_ACT holds while an earlier result waits. A new request is accepted in the
// cycle that commits the previous one, so requests overlap only at that commit.
// Reset (synchronous, active low) empties the table and drops any pending result;
// stored keys and values are not cleared.
`default_nettype none
module compacting_key_value_table #(
    parameter int ENTRIES = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [63:0] i_key,
    input  wire logic [63:0] i_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [63:0]      o_found_value,
    output logic [7:0]       o_entry_count
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_ACT  = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [1:0]          r_kind;
    kvt_pkg::t_cmd       r_cmd;
    logic                r_out_valid, n_out_valid;
    logic [2:0]          r_status, n_status;
    logic [63:0]         r_found, n_found;
    logic [7:0]          r_out_count;

    kvt_pkg::t_ctl       w_ctl;
    logic                w_out_free;
    logic                w_accept;
    logic                w_commit;
    logic [ENTRIES-1:0]  w_hit;
    logic [ENTRIES-1:0]  w_shift;
    logic                w_any;
    logic [63:0]         w_sel_value;
    logic [63:0]         w_keys   [ENTRIES];
    logic [63:0]         w_values [ENTRIES];

    assign w_out_free = !r_out_valid || i_ready;
    assign w_commit   = (r_state == S_ACT) && w_out_free;
    assign o_ready    = (r_state == S_IDLE) || w_commit;
    assign w_accept   = i_valid && o_ready;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [63:0] w_nkey;
        logic [63:0] w_nval;
        if (g == ENTRIES - 1) begin : g_last
            assign w_nkey = w_keys[g];
            assign w_nval = w_values[g];
        end else begin : g_mid
            assign w_nkey = w_keys[g+1];
            assign w_nval = w_values[g+1];
        end
        kvt_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_cmd        (r_cmd),
            .i_count      (r_count),
            .i_shift      (w_shift[g]),
            .i_next_key   (w_nkey),
            .i_next_value (w_nval),
            .o_key        (w_keys[g]),
            .o_value      (w_values[g]),
            .o_hit        (w_hit[g])
        );
    end

    kvt_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .i_hit         (w_hit),
        .i_values      (w_values),
        .o_at_or_after (w_shift),
        .o_any         (w_any),
        .o_found_value (w_sel_value)
    );

    always_comb begin
        w_ctl.cmp = (r_state == S_CMP);
        w_ctl.ins = w_commit && (r_kind == kvt_pkg::REQ_INSERT) && (r_count != FULL_COUNT);
        w_ctl.del = w_commit && (r_kind == kvt_pkg::REQ_DELETE) && w_any;
    end

    always_comb begin
        n_count  = r_count;
        n_status = kvt_pkg::ST_MISSING;
        n_found  = '0;
        case (r_kind)
            kvt_pkg::REQ_INSERT: begin
                if (r_count == FULL_COUNT) begin
                    n_status = kvt_pkg::ST_FULL;
                end else begin
                    n_status = kvt_pkg::ST_INSERTED;
                    n_count  = r_count + CW'(1);
                end
            end
            kvt_pkg::REQ_DELETE: begin
                if (w_any) begin
                    n_status = kvt_pkg::ST_DELETED;
                    n_count  = r_count - CW'(1);
                end
            end
            kvt_pkg::REQ_SEARCH: begin
                if (w_any) begin
                    n_status = kvt_pkg::ST_FOUND;
                    n_found  = w_sel_value;
                end
            end
            default: begin
                n_status = kvt_pkg::ST_MISSING;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_ACT;
            end
            S_ACT: begin
                if (w_commit) begin
                    n_state = w_accept ? S_CMP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_commit) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind      <= i_req_type;
            r_cmd.key   <= i_key;
            r_cmd.value <= i_value;
        end
        if (w_commit) begin
            r_status    <= n_status;
            r_found     <= n_found;
            r_out_count <= 8'(n_count);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_found_value = r_found;
    assign o_entry_count = r_out_count;

endmodule
`default_nettype wire

// File: rtl/kvt_checker.sv
`default_nettype none
module kvt_checker #(
    parameter int ENTRIES = 128
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [2:0]  o_status,
    input wire logic [63:0] o_found_value,
    input wire logic [7:0]  o_entry_count
);

    // A waiting result keeps its status and value until its transfer.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_found_value))
        else $error("result changed while stalled");

    // Only a successful search carries a value.
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != kvt_pkg::ST_FOUND) |-> o_found_value == 64'd0)
        else $error("nonzero value without a match");

    // A full answer reports the table at capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == kvt_pkg::ST_FULL) |-> o_entry_count == 8'(ENTRIES))
        else $error("full reported below capacity");

    // Of two consecutive successful inserts, the second reports a count one above the first.
    a_insert_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && (o_status == kvt_pkg::ST_INSERTED) ##1
        (o_valid && (o_status == kvt_pkg::ST_INSERTED) && !$stable(o_entry_count))
        |-> o_entry_count == $past(o_entry_count) + 8'd1)
        else $error("insert count step wrong");

endmodule

bind compacting_key_value_table kvt_checker #(
    .ENTRIES (ENTRIES)
) u_kvt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_found_value (o_found_value),
    .o_entry_count (o_entry_count)
);
`default_nettype wire
